/* rtl/core/weighted_adjacency_matrix_store_unit_macros.svh */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: assertion macros
// Shared concurrent assertion forms for the matrix store modules.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_ADJACENCY_MATRIX_STORE_UNIT_MACROS_SVH
`define WEIGHTED_ADJACENCY_MATRIX_STORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WAMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("matrix store assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WAMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("matrix store assertion failed");

`endif

/* rtl/core/wams_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: package
// Word types, command and status codes, and store control shared by modules.
// ----------------------------------------------------------------------------
package wams_pkg;

    localparam int VTX_W   = 6;
    localparam int VAL_W   = 16;
    localparam int TOTAL_W = 11;
    localparam int IDX_W   = 7;
    localparam int CFG_W   = 6;
    localparam int CFGI_W  = 2;

    localparam logic [TOTAL_W-1:0] EDGE_MAX = 11'd2047;

    typedef enum logic [3:0] {
        CMD_SET_EDGE = 4'd0,
        CMD_DEL_EDGE = 4'd1,
        CMD_RD_EDGE  = 4'd2,
        CMD_FIRST    = 4'd3,
        CMD_NEXT     = 4'd4,
        CMD_OUT_DEG  = 4'd5,
        CMD_IN_DEG   = 4'd6,
        CMD_GET_MARK = 4'd7,
        CMD_SET_MARK = 4'd8
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    typedef enum logic [CFGI_W-1:0] {
        CFG_VERTEX_COUNT = 2'd0,
        CFG_DIRECTED     = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [VAL_W-1:0] value_in;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [VAL_W-1:0]   value_out;
        logic               edge_present;
        logic [TOTAL_W-1:0] edge_total;
    } t_result_word;

    typedef struct packed {
        logic mat_re;
        logic mat_we;
        logic mark_re;
        logic mark_we;
    } t_store_ctl;

endpackage

/* rtl/core/wams_store.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: memories
// Matrix and mark memories with registered reads and a clearing sweep
// that zeroes both after reset.
// ----------------------------------------------------------------------------
module wams_store #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16,
    parameter int MARK_BITS    = 16,
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES,
    localparam int AW    = $clog2(DEPTH),
    localparam int RB    = $clog2(MAX_VERTICES)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wams_pkg::t_store_ctl   i_ctl,
    input  logic [AW-1:0]          i_mat_addr,
    input  logic [WEIGHT_BITS-1:0] i_mat_wdata,
    input  logic [RB-1:0]          i_mark_addr,
    input  logic [MARK_BITS-1:0]   i_mark_wdata,
    output logic [WEIGHT_BITS-1:0] o_mat_rdata,
    output logic [MARK_BITS-1:0]   o_mark_rdata,
    output logic                   o_clearing
);
    import wams_pkg::*;

    `include "weighted_adjacency_matrix_store_unit_macros.svh"

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [WEIGHT_BITS-1:0] r_mat  [DEPTH];
    logic [MARK_BITS-1:0]   r_mark [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] r_mat_rdata;
    logic [MARK_BITS-1:0]   r_mark_rdata;
    logic                   r_clearing;
    logic [AW-1:0]          r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= AW'(r_clr_addr + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mat[r_clr_addr] <= '0;
        end else if (i_ctl.mat_we) begin
            r_mat[i_mat_addr] <= i_mat_wdata;
        end
        if (i_ctl.mat_re) begin
            r_mat_rdata <= r_mat[i_mat_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            if (r_clr_addr < AW'(MAX_VERTICES)) begin
                r_mark[r_clr_addr[RB-1:0]] <= '0;
            end
        end else if (i_ctl.mark_we) begin
            r_mark[i_mark_addr] <= i_mark_wdata;
        end
        if (i_ctl.mark_re) begin
            r_mark_rdata <= r_mark[i_mark_addr];
        end
    end

    assign o_mat_rdata  = r_mat_rdata;
    assign o_mark_rdata = r_mark_rdata;
    assign o_clearing   = r_clearing;

    `WAMS_ASSERT_IMPL(a_no_access_clr, i_clk, i_rst_n, r_clearing,
        !(i_ctl.mat_we || i_ctl.mat_re || i_ctl.mark_we || i_ctl.mark_re))
    `WAMS_ASSERT_NEXT(a_clr_step, i_clk, i_rst_n,
        r_clearing && (r_clr_addr != LAST_ADDR),
        r_clearing && (r_clr_addr == AW'($past(r_clr_addr) + 1'b1)))
    `WAMS_ASSERT_NEXT(a_clr_end, i_clk, i_rst_n,
        r_clearing && (r_clr_addr == LAST_ADDR), !r_clearing)

endmodule

/* rtl/core/weighted_adjacency_matrix_store_unit.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store unit
// Keeps a weighted adjacency matrix, a mark per vertex and an edge count,
// and answers one result word for every command word.
//
//   Channel   Handshake                    Payload
//   command   start, busy                  i_cmd (t_cmd_word)
//   result    o_done (one-cycle strobe)    o_result (t_result_word)
//   config    i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// Range errors, zero weights, unknown commands and set mark answer in the
// cycle after acceptance; get mark and read weight answer after the memory
// read, set and delete edge after the write, and in undirected mode after a
// further mirrored write. Neighbor and degree scans read one matrix entry per
// cycle from the single read port, up to vertex count entries.
// After reset the unit holds busy while a sweep zeroes all MAX_VERTICES *
// MAX_VERTICES matrix entries and the marks.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module weighted_adjacency_matrix_store_unit #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16,
    parameter int MARK_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  wams_pkg::t_cmd_word                 i_cmd,
    output logic                                o_done,
    output wams_pkg::t_result_word              o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wams_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [wams_pkg::CFG_W-1:0]          i_cfg_data
);
    import wams_pkg::*;

    `include "weighted_adjacency_matrix_store_unit_macros.svh"

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RB    = $clog2(MAX_VERTICES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_MIRROR,
        S_MARK,
        S_SCAN
    } t_state;

    t_state                 r_state;
    t_result_word           r_res;
    logic                   r_done;
    logic [3:0]             r_cmd;
    logic [VTX_W-1:0]       r_a;
    logic [VTX_W-1:0]       r_b;
    logic [WEIGHT_BITS-1:0] r_w;
    logic [IDX_W-1:0]       r_n;
    logic                   r_col;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_pend;
    logic [IDX_W-1:0]       r_pend_idx;
    logic [IDX_W-1:0]       r_deg;
    logic [TOTAL_W-1:0]     r_edges;
    logic [VTX_W-1:0]       r_vcount;
    logic                   r_directed;

    t_store_ctl             w_ctl;
    logic [AW-1:0]          w_mat_addr;
    logic [WEIGHT_BITS-1:0] w_mat_wdata;
    logic [MARK_BITS-1:0]   w_mark_wdata;
    logic [WEIGHT_BITS-1:0] w_mat_rdata;
    logic [MARK_BITS-1:0]   w_mark_rdata;
    logic                   w_clearing;
    logic                   w_accept;
    logic [IDX_W-1:0]       w_n;
    logic                   w_need_b;
    logic                   w_range_err;
    logic [31:0]            w_val32;
    logic [WEIGHT_BITS-1:0] w_weight_in;
    logic [31:0]            w_rd32;
    logic [31:0]            w_mark32;
    logic                   w_issue;
    logic                   w_hit;
    logic                   w_find;
    logic [TOTAL_W-1:0]     w_edges_set;
    logic [TOTAL_W-1:0]     w_edges_del;

    function automatic logic [AW-1:0] mat_addr(input logic [RB-1:0] row,
                                               input logic [RB-1:0] col);
        return AW'(AW'(row) * AW'(MAX_VERTICES)) + AW'(col);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign busy        = w_clearing || (r_state != S_IDLE);
    assign w_accept    = start && !busy;

    assign w_n = (IDX_W'(r_vcount) > IDX_W'(MAX_VERTICES)) ? IDX_W'(MAX_VERTICES)
                                                             : IDX_W'(r_vcount);
    assign w_need_b = (i_cmd.cmd == CMD_SET_EDGE) || (i_cmd.cmd == CMD_DEL_EDGE) ||
                      (i_cmd.cmd == CMD_RD_EDGE)  || (i_cmd.cmd == CMD_NEXT);
    assign w_range_err = (i_cmd.cmd <= CMD_SET_MARK) &&
                         ((IDX_W'(i_cmd.vertex_a) >= w_n) ||
                          (w_need_b && (IDX_W'(i_cmd.vertex_b) >= w_n)));

    assign w_val32      = 32'(i_cmd.value_in);
    assign w_weight_in  = w_val32[WEIGHT_BITS-1:0];
    assign w_mark_wdata = w_val32[MARK_BITS-1:0];
    assign w_rd32       = 32'(w_mat_rdata);
    assign w_mark32     = 32'(w_mark_rdata);

    assign w_issue = r_idx < r_n;
    assign w_hit   = r_pend && (w_mat_rdata != '0);
    assign w_find  = (r_cmd == CMD_FIRST) || (r_cmd == CMD_NEXT);

    assign w_edges_set = ((w_mat_rdata == '0) && (r_edges < EDGE_MAX))
                         ? TOTAL_W'(r_edges + 1'b1) : r_edges;
    assign w_edges_del = ((w_mat_rdata != '0) && (r_edges != '0))
                         ? TOTAL_W'(r_edges - 1'b1) : r_edges;

    always_comb begin
        w_ctl       = '0;
        w_mat_addr  = mat_addr(r_a[RB-1:0], r_b[RB-1:0]);
        w_mat_wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                w_mat_addr = mat_addr(i_cmd.vertex_a[RB-1:0], i_cmd.vertex_b[RB-1:0]);
                if (w_accept && !w_range_err) begin
                    w_ctl.mat_re  = (i_cmd.cmd == CMD_SET_EDGE) ||
                                    (i_cmd.cmd == CMD_DEL_EDGE) ||
                                    (i_cmd.cmd == CMD_RD_EDGE);
                    w_ctl.mark_re = (i_cmd.cmd == CMD_GET_MARK);
                    w_ctl.mark_we = (i_cmd.cmd == CMD_SET_MARK);
                end
            end
            S_EDGE: begin
                w_ctl.mat_we = (r_cmd == CMD_SET_EDGE) || (r_cmd == CMD_DEL_EDGE);
                w_mat_wdata  = (r_cmd == CMD_SET_EDGE) ? r_w : '0;
            end
            S_MIRROR: begin
                w_ctl.mat_we = 1'b1;
                w_mat_addr   = mat_addr(r_b[RB-1:0], r_a[RB-1:0]);
                w_mat_wdata  = (r_cmd == CMD_SET_EDGE) ? r_w : '0;
            end
            S_MARK: begin
            end
            S_SCAN: begin
                w_ctl.mat_re = w_issue;
                w_mat_addr   = r_col ? mat_addr(r_idx[RB-1:0], r_a[RB-1:0])
                                     : mat_addr(r_a[RB-1:0], r_idx[RB-1:0]);
            end
            default: begin
            end
        endcase
    end

    wams_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .MARK_BITS    (MARK_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_mat_addr   (w_mat_addr),
        .i_mat_wdata  (w_mat_wdata),
        .i_mark_addr  (i_cmd.vertex_a[RB-1:0]),
        .i_mark_wdata (w_mark_wdata),
        .o_mat_rdata  (w_mat_rdata),
        .o_mark_rdata (w_mark_rdata),
        .o_clearing   (w_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount   <= '0;
            r_directed <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_VERTEX_COUNT) begin
                r_vcount <= i_cfg_data;
            end else if (i_cfg_index == CFG_DIRECTED) begin
                r_directed <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_edges <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= i_cmd.cmd;
                        r_a   <= i_cmd.vertex_a;
                        r_b   <= i_cmd.vertex_b;
                        r_w   <= w_weight_in;
                        r_n   <= w_n;
                        r_col <= 1'b0;
                        r_deg <= '0;
                        r_res.status       <= ST_OK;
                        r_res.value_out    <= '0;
                        r_res.edge_present <= 1'b0;
                        r_res.edge_total   <= r_edges;
                        if (w_range_err) begin
                            r_res.status <= ST_RANGE;
                            r_done       <= 1'b1;
                        end else begin
                            unique case (i_cmd.cmd)
                                CMD_SET_EDGE: begin
                                    if (w_weight_in == '0) begin
                                        r_res.status <= ST_ZERO;
                                        r_done       <= 1'b1;
                                    end else begin
                                        r_state <= S_EDGE;
                                    end
                                end
                                CMD_DEL_EDGE, CMD_RD_EDGE: begin
                                    r_state <= S_EDGE;
                                end
                                CMD_FIRST, CMD_OUT_DEG: begin
                                    r_idx   <= '0;
                                    r_state <= S_SCAN;
                                end
                                CMD_NEXT: begin
                                    r_idx   <= IDX_W'(IDX_W'(i_cmd.vertex_b) + 1'b1);
                                    r_state <= S_SCAN;
                                end
                                CMD_IN_DEG: begin
                                    r_idx   <= '0;
                                    r_col   <= r_directed;
                                    r_state <= S_SCAN;
                                end
                                CMD_GET_MARK: begin
                                    r_state <= S_MARK;
                                end
                                default: begin
                                    r_done <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_EDGE: begin
                    if (r_cmd == CMD_RD_EDGE) begin
                        r_res.value_out    <= w_rd32[VAL_W-1:0];
                        r_res.edge_present <= (w_mat_rdata != '0);
                        r_done             <= 1'b1;
                        r_state            <= S_IDLE;
                    end else begin
                        if (r_cmd == CMD_SET_EDGE) begin
                            r_edges            <= w_edges_set;
                            r_res.edge_total   <= w_edges_set;
                            r_res.edge_present <= 1'b1;
                        end else begin
                            r_edges          <= w_edges_del;
                            r_res.edge_total <= w_edges_del;
                        end
                        if (r_directed) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_MIRROR;
                        end
                    end
                end
                S_MIRROR: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_MARK: begin
                    r_res.value_out <= w_mark32[VAL_W-1:0];
                    r_done          <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_SCAN: begin
                    if (w_find && w_hit) begin
                        r_res.value_out <= VAL_W'(r_pend_idx);
                        r_done          <= 1'b1;
                        r_pend          <= 1'b0;
                        r_state         <= S_IDLE;
                    end else if (!w_issue && !r_pend) begin
                        r_res.value_out <= w_find ? VAL_W'(r_n) : VAL_W'(r_deg);
                        r_done          <= 1'b1;
                        r_state         <= S_IDLE;
                    end else begin
                        if (w_hit) begin
                            r_deg <= IDX_W'(r_deg + 1'b1);
                        end
                        r_pend <= w_issue;
                        if (w_issue) begin
                            r_pend_idx <= r_idx;
                            r_idx      <= IDX_W'(r_idx + 1'b1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `WAMS_ASSERT_IMPL(a_pend_in_scan, i_clk, i_rst_n, r_pend, r_state == S_SCAN)
    `WAMS_ASSERT_IMPL(a_idx_bound, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= r_n)
    `WAMS_ASSERT_NEXT(a_err_answers, i_clk, i_rst_n, w_accept && w_range_err,
        o_done && (o_result.status == ST_RANGE))

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store unit: regression bench
// Drives command words and register writes with random gaps, keeps its own
// copy of the matrix, marks and edge count, and checks each result word
// against the answer worked out from that copy or, for checked table rows,
// the answer written in the plan. A directed table comes first, then random
// phases over several vertex counts and both modes, and last a mode-switching
// climb that pushes the edge count above the number of live entries.
// ----------------------------------------------------------------------------
module tb;
    import wams_pkg::*;

    localparam int          MAXV          = 32;
    localparam logic [3:0]  CMD_LAST_CODE = 4'd15;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int          PHASE_COUNT   = 10;
    localparam int          PHASE_ITEMS   = 100;
    localparam int          CLIMB_ROUNDS  = 60;

    typedef struct {
        bit               is_reg;
        t_cfg_index       reg_sel;
        logic [CFG_W-1:0] reg_val;
        t_cmd_word        word;
        bit               typed;
        t_result_word     want;
    } t_plan_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_cmd_word           i_cmd;
    logic                o_done;
    t_result_word        o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFGI_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    logic [VAL_W-1:0]    weights [0:MAXV-1][0:MAXV-1];
    logic [VAL_W-1:0]    marks [0:MAXV-1];
    logic [TOTAL_W-1:0]  edge_tally;
    logic [CFG_W-1:0]    vtx_count_reg;
    logic                directed_reg;

    t_result_word        awaited_answers [$];
    t_plan_row           plan [$];
    int unsigned         fail_count  = 0;
    int unsigned         cycle_count = 0;
    int                  idle_pct    = 27;

    int                  phase_vc [PHASE_COUNT] = '{32, 4, 63, 0, 1, 8, 33, 2, 32, 0};
    bit                  phase_dir [PHASE_COUNT] = '{0, 1, 1, 0, 1, 0, 0, 1, 1, 0};

    weighted_adjacency_matrix_store_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int active_vertices();
        return (vtx_count_reg > MAXV) ? MAXV : int'(vtx_count_reg);
    endfunction

    function automatic t_result_word graph_answer(t_cmd_word w);
        t_result_word r;
        int           n;
        int           a;
        int           b;
        int           i;
        int           from;
        bit           need_b;
        bit           by_column;
        n = active_vertices();
        a = w.vertex_a;
        b = w.vertex_b;
        need_b = (w.cmd <= CMD_RD_EDGE) || (w.cmd == CMD_NEXT);
        r = '0;
        r.status = ST_OK;
        if (w.cmd <= CMD_SET_MARK && (a >= n || (need_b && b >= n))) begin
            r.status = ST_RANGE;
        end else begin
            case (w.cmd)
                CMD_SET_EDGE: begin
                    if (w.value_in == '0) begin
                        r.status = ST_ZERO;
                    end else begin
                        if (weights[a][b] == '0 && edge_tally < EDGE_MAX) begin
                            edge_tally = edge_tally + 1'b1;
                        end
                        weights[a][b] = w.value_in;
                        if (!directed_reg) begin
                            weights[b][a] = w.value_in;
                        end
                        r.edge_present = 1'b1;
                    end
                end
                CMD_DEL_EDGE: begin
                    if (weights[a][b] != '0 && edge_tally > 0) begin
                        edge_tally = edge_tally - 1'b1;
                    end
                    weights[a][b] = '0;
                    if (!directed_reg) begin
                        weights[b][a] = '0;
                    end
                end
                CMD_RD_EDGE: begin
                    r.value_out = weights[a][b];
                    r.edge_present = (weights[a][b] != '0);
                end
                CMD_FIRST, CMD_NEXT: begin
                    from = (w.cmd == CMD_FIRST) ? 0 : b + 1;
                    r.value_out = VAL_W'(n);
                    for (i = from; i < n; i++) begin
                        if (weights[a][i] != '0 && r.value_out == VAL_W'(n)) begin
                            r.value_out = VAL_W'(i);
                        end
                    end
                end
                CMD_OUT_DEG, CMD_IN_DEG: begin
                    by_column = (w.cmd == CMD_IN_DEG) && directed_reg;
                    for (i = 0; i < n; i++) begin
                        if ((by_column ? weights[i][a] : weights[a][i]) != '0) begin
                            r.value_out = r.value_out + 1'b1;
                        end
                    end
                end
                CMD_GET_MARK: r.value_out = marks[a];
                CMD_SET_MARK: marks[a] = w.value_in;
                default: ;
            endcase
        end
        if (r.status != ST_OK) begin
            r.value_out = '0;
            r.edge_present = 1'b0;
        end
        r.edge_total = edge_tally;
        return r;
    endfunction

    function automatic logic [VTX_W-1:0] pick_vertex();
        int n;
        n = active_vertices();
        if (n > 0 && $urandom_range(0, 99) < 85) begin
            return VTX_W'($urandom_range(0, n - 1));
        end
        return VTX_W'($urandom_range(0, 63));
    endfunction

    function automatic void plan_cmd(logic [3:0] cmd, int a, int b, int val);
        t_plan_row row;
        row.is_reg  = 1'b0;
        row.reg_sel = CFG_VERTEX_COUNT;
        row.reg_val = '0;
        row.word    = {cmd, VTX_W'(a), VTX_W'(b), VAL_W'(val)};
        row.typed   = 1'b0;
        row.want    = '0;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void plan_chk(logic [3:0] cmd, int a, int b, int val,
                                     t_status st, int vout, bit present, int total);
        plan_cmd(cmd, a, b, val);
        plan[plan.size() - 1].typed = 1'b1;
        plan[plan.size() - 1].want  = {st, VAL_W'(vout), present, TOTAL_W'(total)};
    endfunction

    function automatic void plan_reg(t_cfg_index sel, int val);
        plan_cmd(CMD_SET_EDGE, 0, 0, 0);
        plan[plan.size() - 1].is_reg  = 1'b1;
        plan[plan.size() - 1].reg_sel = sel;
        plan[plan.size() - 1].reg_val = CFG_W'(val);
    endfunction

    task automatic log_mismatch(string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", what);
        end
    endtask

    task automatic issue_command(t_cmd_word w, bit typed, t_result_word want);
        t_result_word model_out;
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= t_cmd_word'($urandom);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        model_out = graph_answer(w);
        awaited_answers.insert(awaited_answers.size(), typed ? want : model_out);
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        start <= 1'b0;
        i_cmd <= t_cmd_word'($urandom);
        while (awaited_answers.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index sel, logic [CFG_W-1:0] val);
        wait_quiet();
        while ($urandom_range(0, 99) < idle_pct) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (sel == CFG_VERTEX_COUNT) begin
            vtx_count_reg = val;
        end else begin
            directed_reg = val[0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFGI_W'($urandom);
        i_cfg_data  <= CFG_W'($urandom);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result_word want;
        if (i_rst_n && o_done) begin
            if (awaited_answers.size() == 0) begin
                log_mismatch($sformatf("unexpected result word: status %0d value %0d",
                                       o_result.status, o_result.value_out));
            end else begin
                want = awaited_answers.pop_front();
                if (o_result.status !== want.status
                    || o_result.value_out !== want.value_out
                    || o_result.edge_present !== want.edge_present
                    || o_result.edge_total !== want.edge_total) begin
                    log_mismatch($sformatf(
                        "result mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                        want.status, want.value_out, want.edge_present, want.edge_total,
                        o_result.status, o_result.value_out, o_result.edge_present,
                        o_result.edge_total));
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("weighted_adjacency_matrix_store_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int        k;
        int        p;
        int        sel;
        t_cmd_word w;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        for (k = 0; k < MAXV; k++) begin
            marks[k] = '0;
            for (p = 0; p < MAXV; p++) begin
                weights[k][p] = '0;
            end
        end
        edge_tally    = '0;
        vtx_count_reg = '0;
        directed_reg  = 1'b0;

        plan_chk(CMD_RD_EDGE, 0, 0, 0, ST_RANGE, 0, 0, 0);
        plan_chk(CMD_LAST_CODE, 63, 63, 16'hFFFF, ST_OK, 0, 0, 0);
        plan_reg(CFG_VERTEX_COUNT, 32);
        plan_reg(CFG_DIRECTED, 0);
        plan_chk(CMD_SET_EDGE, 0, 31, 0, ST_ZERO, 0, 0, 0);
        plan_chk(CMD_SET_EDGE, 32, 0, 0, ST_RANGE, 0, 0, 0);
        plan_chk(CMD_SET_EDGE, 0, 31, 16'hFFFF, ST_OK, 0, 1, 1);
        plan_chk(CMD_SET_EDGE, 31, 0, 1, ST_OK, 0, 1, 1);
        plan_chk(CMD_RD_EDGE, 31, 0, 0, ST_OK, 1, 1, 1);
        plan_cmd(CMD_FIRST, 0, 0, 0);
        plan_cmd(CMD_NEXT, 0, 31, 0);
        plan_chk(CMD_NEXT, 31, 63, 0, ST_RANGE, 0, 0, 1);
        plan_cmd(CMD_OUT_DEG, 0, 0, 0);
        plan_cmd(CMD_IN_DEG, 31, 0, 0);
        plan_chk(CMD_SET_MARK, 31, 0, 16'hFFFF, ST_OK, 0, 0, 1);
        plan_chk(CMD_GET_MARK, 31, 0, 0, ST_OK, 16'hFFFF, 0, 1);
        plan_chk(CMD_GET_MARK, 63, 0, 0, ST_RANGE, 0, 0, 1);
        plan_chk(CMD_DEL_EDGE, 0, 31, 0, ST_OK, 0, 0, 0);
        plan_chk(CMD_DEL_EDGE, 0, 31, 0, ST_OK, 0, 0, 0);
        plan_chk(CMD_SET_EDGE, 2, 3, 7, ST_OK, 0, 1, 1);
        plan_reg(CFG_DIRECTED, 1);
        plan_chk(CMD_DEL_EDGE, 2, 3, 0, ST_OK, 0, 0, 0);
        plan_chk(CMD_DEL_EDGE, 3, 2, 0, ST_OK, 0, 0, 0);
        plan_cmd(CMD_SET_EDGE, 5, 6, 16'h1234);
        plan_cmd(CMD_IN_DEG, 6, 0, 0);
        plan_reg(CFG_VERTEX_COUNT, 63);
        plan_cmd(CMD_FIRST, 5, 0, 0);
        plan_chk(CMD_SET_EDGE, 63, 63, 1, ST_RANGE, 0, 0, 1);
        plan_reg(CFG_VERTEX_COUNT, 1);
        plan_cmd(CMD_FIRST, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                write_register(plan[k].reg_sel, plan[k].reg_val);
            end else begin
                issue_command(plan[k].word, plan[k].typed, plan[k].want);
            end
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            if (p == PHASE_COUNT - 1) begin
                write_register(CFG_VERTEX_COUNT, CFG_W'($urandom_range(0, 63)));
                write_register(CFG_DIRECTED, CFG_W'($urandom_range(0, 1)));
            end else begin
                write_register(CFG_VERTEX_COUNT, CFG_W'(phase_vc[p]));
                write_register(CFG_DIRECTED, CFG_W'(phase_dir[p]));
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 30) w.cmd = CMD_SET_EDGE;
                else if (sel < 38) w.cmd = CMD_DEL_EDGE;
                else if (sel < 50) w.cmd = CMD_RD_EDGE;
                else if (sel < 58) w.cmd = CMD_FIRST;
                else if (sel < 68) w.cmd = CMD_NEXT;
                else if (sel < 76) w.cmd = CMD_OUT_DEG;
                else if (sel < 84) w.cmd = CMD_IN_DEG;
                else if (sel < 90) w.cmd = CMD_GET_MARK;
                else if (sel < 96) w.cmd = CMD_SET_MARK;
                else w.cmd = 4'($urandom_range(CMD_SET_MARK + 1, CMD_LAST_CODE));
                w.vertex_a = pick_vertex();
                w.vertex_b = pick_vertex();
                sel = $urandom_range(0, 19);
                w.value_in = (sel == 0) ? '0 : (sel == 1) ? 16'hFFFF : VAL_W'($urandom);
                issue_command(w, 1'b0, '0);
            end
        end

        // Each round sets both directions as two counted edges, then removes
        // them with one undirected delete, so the count climbs by one.
        idle_pct = 0;
        write_register(CFG_VERTEX_COUNT, 2);
        for (k = 0; k < CLIMB_ROUNDS; k++) begin
            write_register(CFG_DIRECTED, 1);
            issue_command({CMD_SET_EDGE, 6'd0, 6'd1, 16'($urandom_range(1, 65535))},
                          1'b0, '0);
            issue_command({CMD_SET_EDGE, 6'd1, 6'd0, 16'($urandom_range(1, 65535))},
                          1'b0, '0);
            write_register(CFG_DIRECTED, 0);
            issue_command({CMD_DEL_EDGE, 6'd0, 6'd1, 16'($urandom)}, 1'b0, '0);
        end

        wait_quiet();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && awaited_answers.size() == 0) begin
            $display("weighted_adjacency_matrix_store_unit regression: pass");
        end else begin
            $display("weighted_adjacency_matrix_store_unit regression: fail");
        end
        $finish;
    end

endmodule
